[rtl/core/pair_transition_hash_counter_macros.svh]
// Assertion macros used by the pair transition hash counter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PAIR_TRANSITION_HASH_COUNTER_MACROS_SVH
`define PAIR_TRANSITION_HASH_COUNTER_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define PTHC_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset.
`define PTHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pthc_pkg.sv]
// Package for the pair transition hash counter: mixing constants, slot
// entry layout and sequencer states. No dependencies.
package pthc_pkg;

    localparam int unsigned SLOTS_DEFAULT = 1024;

    localparam logic [63:0] MIX_MUL_A     = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B     = 64'h94d0_49bb_1331_11eb;
    localparam logic [63:0] GOLDEN_OFFSET = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [31:0] COUNT_MAX     = 32'hffff_ffff;

    localparam int unsigned SYM_W  = 64;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned IN_W   = 2 * SYM_W;
    localparam int unsigned OUT_W  = 40;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic [SYM_W-1:0] second;
        logic [SYM_W-1:0] first;
    } slot_entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADD,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

endpackage

[rtl/core/pthc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pthc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/pair_transition_hash_counter.sv]
// Pair transition hash counter: top level with hash sequencer and prober.
// Depends on pthc_pkg, pthc_ram and pair_transition_hash_counter_macros.svh.
//
// Counts ordered pairs of 64-bit symbols in an open-addressed table of SLOTS
// entries (power of two). After reset the block sweeps the table clear, one
// slot per cycle, and holds s_axis_tready low meanwhile. One item is handled at
// a time. The pair hash runs on a single shared 32x32 multiplier: four 64-bit
// multiplies, with 64-bit adds between the second and third. Each probed slot
// takes one table read and one compare/write step on the single table RAM; one
// slot is probed on a hit at the home slot and at most SLOTS when the table is
// full.
`include "pair_transition_hash_counter_macros.svh"

module pair_transition_hash_counter #(
    parameter int unsigned SLOTS = pthc_pkg::SLOTS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [63:0] first_symbol, [127:64] second_symbol
    input  logic [pthc_pkg::IN_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [0] was_present, [32:1] pair_count, [33] table_full, [39:34] zero
    output logic [pthc_pkg::OUT_W-1:0] m_axis_tdata
);

    import pthc_pkg::*;

    localparam int unsigned IDX_W   = $clog2(SLOTS);
    localparam int unsigned ENTRY_W = $bits(slot_entry_t);

    // control
    state_t           state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       sel_reg, sel_next;
    logic [1:0]       add_cnt_reg, add_cnt_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    // payload
    logic             op_reg, op_next;
    logic [SYM_W-1:0] first_reg, first_next;
    logic [SYM_W-1:0] second_reg, second_next;
    logic [63:0]      v_reg, v_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      prod_reg, prod_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic             out_present_reg, out_present_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             out_full_reg, out_full_next;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_const;
    logic [63:0] mul_full;
    logic [63:0] mul_res;

    // table RAM
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    slot_entry_t        ram_wr_entry;
    logic               ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;
    slot_entry_t        rd_entry;
    logic               key_hit;
    logic [CNT_W-1:0]   count_inc;

    assign mul_const = sel_reg[0] ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a     = (phase_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b     = (phase_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_full  = 64'(mul_a) * 64'(mul_b);
    // low 64 bits of the full product: cross terms only touch the upper half
    assign mul_res   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};

    assign rd_entry  = ram_rd_data;
    assign key_hit   = (rd_entry.first == first_reg) && (rd_entry.second == second_reg);
    assign count_inc = (rd_entry.count == COUNT_MAX) ? rd_entry.count
                                                     : rd_entry.count + 32'd1;

    pthc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            phase_reg   <= 2'd0;
            sel_reg     <= 2'd0;
            add_cnt_reg <= 2'd0;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            sel_reg     <= sel_next;
            add_cnt_reg <= add_cnt_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        first_reg       <= first_next;
        second_reg      <= second_next;
        v_reg           <= v_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        idx_reg         <= idx_next;
        probe_reg       <= probe_next;
        out_present_reg <= out_present_next;
        out_count_reg   <= out_count_next;
        out_full_reg    <= out_full_next;
    end

    always_comb
    begin
        logic [63:0] mix_x;
        logic [63:0] hash;

        mix_x            = '0;
        hash             = '0;
        state_next       = state_reg;
        phase_next       = phase_reg;
        sel_next         = sel_reg;
        add_cnt_next     = add_cnt_reg;
        clr_next         = clr_reg;
        op_next          = op_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        v_next           = v_reg;
        acc_next         = acc_reg;
        prod_next        = mul_full;
        idx_next         = idx_reg;
        probe_next       = probe_reg;
        out_present_next = out_present_reg;
        out_count_next   = out_count_reg;
        out_full_next    = out_full_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg;
        ram_wr_entry     = '0;
        ram_rd_en        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                clr_next    = clr_reg + IDX_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser[0];
                    first_next  = s_axis_tdata[SYM_W-1:0];
                    second_next = s_axis_tdata[IN_W-1:SYM_W];
                    v_next      = s_axis_tdata[IN_W-1:SYM_W]
                                  ^ (s_axis_tdata[IN_W-1:SYM_W] >> 30);
                    sel_next    = 2'd0;
                    phase_next  = 2'd0;
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        acc_next[63:32] = acc_reg[63:32] + prod_reg[31:0];
                    end
                    default:
                    begin
                        if (!sel_reg[0])
                        begin
                            v_next   = mul_res ^ (mul_res >> 27);
                            sel_next = sel_reg + 2'd1;
                        end
                        else if (!sel_reg[1])
                        begin
                            v_next       = mul_res ^ (mul_res >> 31);
                            add_cnt_next = 2'd0;
                            state_next   = S_ADD;
                        end
                        else
                        begin
                            hash       = mul_res ^ (mul_res >> 31);
                            idx_next   = hash[IDX_W-1:0];
                            probe_next = '0;
                            state_next = S_READ;
                        end
                    end
                endcase
            end

            S_ADD:
            begin
                add_cnt_next = add_cnt_reg + 2'd1;
                case (add_cnt_reg)
                    2'd0:
                    begin
                        v_next = v_reg + GOLDEN_OFFSET;
                    end
                    2'd1:
                    begin
                        v_next = v_reg + (first_reg << 6);
                    end
                    default:
                    begin
                        // fold in the first symbol, then start the outer finalizer
                        mix_x      = first_reg ^ (v_reg + (first_reg >> 2));
                        v_next     = mix_x ^ (mix_x >> 30);
                        sel_next   = 2'd2;
                        phase_next = 2'd0;
                        state_next = S_MUL;
                    end
                endcase
            end

            S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                ram_wr_entry.valid  = 1'b1;
                ram_wr_entry.first  = first_reg;
                ram_wr_entry.second = second_reg;
                if (!rd_entry.valid)
                begin
                    // claim the empty slot on add
                    ram_wr_en          = !op_reg;
                    ram_wr_entry.count = 32'd1;
                    out_present_next   = 1'b0;
                    out_count_next     = op_reg ? 32'd0 : 32'd1;
                    out_full_next      = 1'b0;
                    state_next         = S_OUT;
                end
                else if (key_hit)
                begin
                    ram_wr_en          = !op_reg;
                    ram_wr_entry.count = count_inc;
                    out_present_next   = 1'b1;
                    out_count_next     = op_reg ? rd_entry.count : count_inc;
                    out_full_next      = 1'b0;
                    state_next         = S_OUT;
                end
                else if (probe_reg == '1)
                begin
                    out_present_next = 1'b0;
                    out_count_next   = '0;
                    out_full_next    = !op_reg;
                    state_next       = S_OUT;
                end
                else
                begin
                    // advance to the next slot, wrapping at the table size
                    idx_next   = idx_reg + IDX_W'(1);
                    probe_next = probe_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end

            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {6'b0, out_full_reg, out_count_reg, out_present_reg};

    `PTHC_ASSERT_NEXT(a_accept_starts_hash, s_axis_tvalid && s_axis_tready, state_reg == S_MUL && sel_reg == 2'd0 && phase_reg == 2'd0, "accepted item did not start the hash")
    `PTHC_ASSERT_HOLD(a_full_is_clean, m_axis_tvalid && out_full_reg, !out_present_reg && out_count_reg == 32'd0, "full result carries a count")
    `PTHC_ASSERT_HOLD(a_present_has_count, m_axis_tvalid && out_present_reg, out_count_reg != 32'd0, "present pair reported with zero count")
    `PTHC_ASSERT_HOLD(a_write_states, ram_wr_en, state_reg == S_CLEAR || state_reg == S_CHECK, "table written outside clear or check")
    `PTHC_ASSERT_HOLD(a_check_after_read, state_reg == S_CHECK, $past(state_reg) == S_READ, "check without a preceding read")

endmodule
